/* sv/smbme_pkg.sv */
// shared types, codes and phase helpers for the smbus master byte engine
`default_nettype none
package smbme_pkg;

  // tick counter width and mask
  localparam int CNT_BITS = 16;
  localparam logic [31:0] CNT_MASK = 32'hFFFF_FFFF >> (32 - CNT_BITS);

  // input command codes
  localparam logic [2:0] FN_TICK  = 3'd0;
  localparam logic [2:0] FN_WAKE  = 3'd1;
  localparam logic [2:0] FN_START = 3'd2;
  localparam logic [2:0] FN_STOP  = 3'd3;
  localparam logic [2:0] FN_WRITE = 3'd4;
  localparam logic [2:0] FN_READ  = 3'd5;

  // operation modes
  localparam logic [2:0] OP_IDLE      = 3'd0;
  localparam logic [2:0] OP_WAKE      = 3'd1;
  localparam logic [2:0] OP_START     = 3'd2;
  localparam logic [2:0] OP_STOP      = 3'd3;
  localparam logic [2:0] OP_WRITE     = 3'd4;
  localparam logic [2:0] OP_READ_ACK  = 3'd5;
  localparam logic [2:0] OP_READ_NACK = 3'd6;

  // configuration register indexes
  localparam logic REG_PHASE_TICKS = 1'b0;
  localparam logic REG_WAKE_TICKS  = 1'b1;

  localparam logic [15:0] PHASE_TICKS_RST = 16'd5;
  localparam logic [15:0] WAKE_TICKS_RST  = 16'd1400;

  typedef logic [CNT_BITS-1:0] cnt_t;

  // sequencer state
  typedef struct packed {
    logic [2:0] op_mode;
    logic [1:0] phase_step;
    logic [3:0] bit_index;
    cnt_t       tick_count;
    logic [7:0] shift_reg;
    logic       scl;
    logic       sda;
    logic       nack;
    logic [7:0] rx_last;
  } st_t;

  // tick count load: zero counts as one, saturate to counter width
  function automatic cnt_t load_count(input logic [15:0] ticks);
    logic [31:0] wide;
    wide = 32'(ticks);
    if (wide == 32'd0) begin
      wide = 32'd1;
    end
    if (wide > CNT_MASK) begin
      wide = CNT_MASK;
    end
    return CNT_BITS'(wide);
  endfunction

  // drive lines for the current phase and load its duration
  function automatic st_t enter_phase(input st_t s, input logic [15:0] pt,
                                      input logic [15:0] wt);
    st_t        n;
    logic [15:0] dur;
    n = s;
    dur = pt;
    case (s.op_mode)
      OP_WAKE: begin
        if (s.phase_step == 2'd0) begin
          n.scl = 1'b1;
          n.sda = 1'b1;
        end else if (s.phase_step == 2'd1) begin
          n.scl = 1'b0;
          dur = wt;
        end else begin
          n.scl = 1'b1;
        end
      end
      OP_START: begin
        if (s.phase_step == 2'd0) n.sda = 1'b1;
        else if (s.phase_step == 2'd1) n.scl = 1'b1;
        else if (s.phase_step == 2'd2) n.sda = 1'b0;
        else n.scl = 1'b0;
      end
      OP_STOP: begin
        if (s.phase_step == 2'd0) n.sda = 1'b0;
        else if (s.phase_step == 2'd1) n.scl = 1'b1;
        else n.sda = 1'b1;
      end
      OP_WRITE: begin
        if (s.bit_index < 4'd8) begin
          if (s.phase_step == 2'd0) n.scl = 1'b0;
          else if (s.phase_step == 2'd1) n.sda = s.shift_reg[7];
          else n.scl = 1'b1;
        end else begin
          if (s.phase_step == 2'd0) begin
            n.scl = 1'b0;
            n.sda = 1'b1;
          end else if (s.phase_step == 2'd1) begin
            n.scl = 1'b1;
          end else begin
            n.scl = 1'b0;
          end
        end
      end
      OP_READ_ACK, OP_READ_NACK: begin
        if (s.bit_index < 4'd8) begin
          if (s.phase_step == 2'd0) begin
            n.scl = 1'b0;
            n.sda = 1'b1;
          end else begin
            n.scl = 1'b1;
          end
        end else begin
          if (s.phase_step == 2'd0) n.scl = 1'b0;
          else if (s.phase_step == 2'd1) n.sda = (s.op_mode == OP_READ_NACK);
          else if (s.phase_step == 2'd2) n.scl = 1'b1;
          else n.scl = 1'b0;
        end
      end
      default: begin
        n = s;
      end
    endcase
    n.tick_count = load_count(dur);
    return n;
  endfunction

endpackage
`default_nettype wire

/* sv/smbme_step.sv */
// next-state logic of the bit sequencer for one item
`default_nettype none
module smbme_step (
  input  var smbme_pkg::st_t st,
  input  wire [2:0]          func,
  input  wire [7:0]          tx_byte,
  input  wire                master_ack,
  input  wire                sda_level,
  input  wire [15:0]         phase_ticks,
  input  wire [15:0]         wake_ticks,
  output smbme_pkg::st_t     st_nxt,
  output logic               done
);

  logic       is_rd;
  logic [1:0] last_step;

  // read mode and last phase index of the current bit or slot
  always_comb begin
    is_rd = (st.op_mode == smbme_pkg::OP_READ_ACK) ||
            (st.op_mode == smbme_pkg::OP_READ_NACK);
    case (st.op_mode)
      smbme_pkg::OP_START: last_step = 2'd3;
      smbme_pkg::OP_WRITE: last_step = 2'd2;
      smbme_pkg::OP_READ_ACK, smbme_pkg::OP_READ_NACK:
        last_step = (st.bit_index < 4'd8) ? 2'd1 : 2'd3;
      default: last_step = 2'd2;
    endcase
  end

  // tick handling, phase end and command start
  always_comb begin
    st_nxt = st;
    done = 1'b0;
    if (func == smbme_pkg::FN_TICK) begin
      if (st.op_mode != smbme_pkg::OP_IDLE) begin
        st_nxt.tick_count = st.tick_count - 1'b1;
        if (st_nxt.tick_count == '0) begin
          // sample at phase end
          if (st.op_mode == smbme_pkg::OP_WRITE) begin
            if (st.bit_index < 4'd8 && st.phase_step == 2'd2) begin
              st_nxt.shift_reg = {st.shift_reg[6:0], 1'b0};
            end else if (st.bit_index >= 4'd8 && st.phase_step == 2'd1) begin
              st_nxt.nack = sda_level;
            end
          end else if (is_rd && st.bit_index < 4'd8 && st.phase_step == 2'd1) begin
            st_nxt.shift_reg = {st.shift_reg[6:0], sda_level};
          end
          // advance phase, bit or finish
          if (st.phase_step < last_step) begin
            st_nxt.phase_step = st.phase_step + 2'd1;
            st_nxt = smbme_pkg::enter_phase(st_nxt, phase_ticks, wake_ticks);
          end else if ((st.op_mode == smbme_pkg::OP_WRITE || is_rd) &&
                       st.bit_index < 4'd8) begin
            st_nxt.bit_index = st.bit_index + 4'd1;
            st_nxt.phase_step = 2'd0;
            st_nxt = smbme_pkg::enter_phase(st_nxt, phase_ticks, wake_ticks);
          end else begin
            if (is_rd) begin
              st_nxt.rx_last = st_nxt.shift_reg;
            end
            st_nxt.op_mode = smbme_pkg::OP_IDLE;
            st_nxt.phase_step = 2'd0;
            st_nxt.bit_index = 4'd0;
            st_nxt.tick_count = '0;
            done = 1'b1;
          end
        end
      end
    end else if (func <= smbme_pkg::FN_READ && st.op_mode == smbme_pkg::OP_IDLE) begin
      st_nxt.phase_step = 2'd0;
      st_nxt.bit_index = 4'd0;
      case (func)
        smbme_pkg::FN_WAKE:  st_nxt.op_mode = smbme_pkg::OP_WAKE;
        smbme_pkg::FN_START: st_nxt.op_mode = smbme_pkg::OP_START;
        smbme_pkg::FN_STOP:  st_nxt.op_mode = smbme_pkg::OP_STOP;
        smbme_pkg::FN_WRITE: begin
          st_nxt.op_mode = smbme_pkg::OP_WRITE;
          st_nxt.shift_reg = tx_byte;
          st_nxt.nack = 1'b0;
        end
        default: begin
          st_nxt.op_mode = master_ack ? smbme_pkg::OP_READ_ACK : smbme_pkg::OP_READ_NACK;
          st_nxt.shift_reg = 8'd0;
        end
      endcase
      st_nxt = smbme_pkg::enter_phase(st_nxt, phase_ticks, wake_ticks);
    end
  end

endmodule
`default_nettype wire

/* sv/smbus_master_byte_engine.sv */
// top level of the smbus master byte engine
// usage:
// - input channel (in_valid / in_stall) carries one item per transfer: a tick
//   (func 0) or a command (wake, start, stop, write byte, read byte)
// - each accepted item gives exactly one result transfer on the out_ channel:
//   line drives, busy, done, last read byte and the write nack flag
// - the sequencer state and the result register are both loaded at the edge
//   that takes the item
// - one item is taken per cycle while in_stall is low; the sequencer update
//   between the state register and the result register is combinational
// - in_stall rises only while a result is held and out_stall is high; the
//   held result does not change and no item is taken until it goes out
// - a command while busy is ignored and reports the current state
// - phase_ticks (addr 0) and wake_hold_ticks (addr 4) are written over the apb
//   port, by the user only while idle (not enforced); reads return the stored value
// - reset (rst_n low, synchronous) idles the sequencer, releases both lines,
//   clears the result valid flag and loads the register defaults 5 and 1400
`default_nettype none
module smbus_master_byte_engine (
  input  wire        clk,
  input  wire        rst_n,
  // item input
  input  wire        in_valid,
  output logic       in_stall,
  input  wire [2:0]  in_func,
  input  wire [7:0]  in_tx_byte,
  input  wire        in_master_ack,
  input  wire        in_sda_level,
  // result output
  output logic       out_valid,
  input  wire        out_stall,
  output logic       out_scl_out,
  output logic       out_sda_out,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic [7:0] out_rx_byte,
  output logic       out_nack_seen,
  // configuration
  input  wire        psel,
  input  wire        penable,
  input  wire        pwrite,
  input  wire [2:0]  paddr,
  input  wire [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready
);

  smbme_pkg::st_t st_r, st_nxt;
  logic [15:0]    phase_ticks_r;
  logic [15:0]    wake_ticks_r;
  logic           out_valid_r;
  logic           done_nxt;
  logic           in_take;
  logic           cfg_wr;

  // handshake
  assign in_stall = out_valid_r & out_stall;
  assign in_take = in_valid & ~in_stall;
  assign out_valid = out_valid_r;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[2] == smbme_pkg::REG_WAKE_TICKS) ? {16'd0, wake_ticks_r}
                                                          : {16'd0, phase_ticks_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= smbme_pkg::PHASE_TICKS_RST;
      wake_ticks_r <= smbme_pkg::WAKE_TICKS_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == smbme_pkg::REG_PHASE_TICKS) begin
        phase_ticks_r <= pwdata[15:0];
      end else begin
        wake_ticks_r <= pwdata[15:0];
      end
    end
  end

  // sequencer next state
  smbme_step u_step (
    .st          (st_r),
    .func        (in_func),
    .tx_byte     (in_tx_byte),
    .master_ack  (in_master_ack),
    .sda_level   (in_sda_level),
    .phase_ticks (phase_ticks_r),
    .wake_ticks  (wake_ticks_r),
    .st_nxt      (st_nxt),
    .done        (done_nxt)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{op_mode: smbme_pkg::OP_IDLE, phase_step: 2'd0, bit_index: 4'd0,
                tick_count: '0, shift_reg: 8'd0, scl: 1'b1, sda: 1'b1,
                nack: 1'b0, rx_last: 8'd0};
    end else if (in_take) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_scl_out <= st_nxt.scl;
      out_sda_out <= st_nxt.sda;
      out_busy_res <= (st_nxt.op_mode != smbme_pkg::OP_IDLE);
      out_done_res <= done_nxt;
      out_rx_byte <= st_nxt.rx_last;
      out_nack_seen <= st_nxt.nack;
    end
  end

endmodule
`default_nettype wire

/* sv/smbme_chk.sv */
// port-level checker for the smbus master byte engine, with its bind
`default_nettype none
module smbme_chk (
  input wire clk,
  input wire rst_n,
  input wire in_valid,
  input wire in_stall,
  input wire out_valid,
  input wire out_stall,
  input wire out_busy_res,
  input wire out_done_res
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // input stall only comes from a held, stalled result
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // a completing transfer never reports busy
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res)
    else $error("done reported while busy");

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // every taken item shows a result next cycle
  a_take_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item gave no result");

endmodule

bind smbus_master_byte_engine smbme_chk u_smbme_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_busy_res (out_busy_res),
  .out_done_res (out_done_res)
);
`default_nettype wire

/* bench/tb_top.sv */
// testbench for the smbus master byte engine: directed table, random bus traffic, self-check
`timescale 1ns / 100ps
module tb_top;

  // codes outside the command set, taken as no-ops
  localparam logic [2:0] FN_NOP6 = 3'd6;
  localparam logic [2:0] FN_NOP7 = 3'd7;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rx;
    logic       nack;
  } line_result_t;

  typedef struct packed {
    logic [2:0]   func;
    logic [7:0]   tx;
    logic         mack;
    logic         sda;
    int           reps;   // negative: ticks until the operation ends
    logic         pinned;
    line_result_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [2:0] in_func = smbme_pkg::FN_TICK;
  logic [7:0] in_tx_byte = 8'h00;
  logic in_master_ack = 1'b0;
  logic in_sda_level = 1'b0;
  logic out_stall = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic in_stall, out_valid, pready;
  logic out_scl_out, out_sda_out, out_busy_res, out_done_res, out_nack_seen;
  logic [7:0] out_rx_byte;
  logic [31:0] prdata;

  smbus_master_byte_engine uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_tx_byte(in_tx_byte), .in_master_ack(in_master_ack), .in_sda_level(in_sda_level),
    .out_valid(out_valid), .out_stall(out_stall), .out_scl_out(out_scl_out),
    .out_sda_out(out_sda_out), .out_busy_res(out_busy_res), .out_done_res(out_done_res),
    .out_rx_byte(out_rx_byte), .out_nack_seen(out_nack_seen),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // bus sequencer copy and its settings
  logic [2:0]  bus_mode;
  logic [1:0]  bus_step;
  logic [15:0] bus_cnt;
  logic [3:0]  bus_bit;
  logic [7:0]  bus_shift;
  logic        bus_scl, bus_sda, bus_nack;
  logic [7:0]  bus_rx;
  logic [15:0] cfg_phase, cfg_wake;

  line_result_t line_q[$];
  plan_row_t plan [24];
  int errors = 0;
  int cycles = 0;
  int n_items = 0;
  int n_ignored = 0;
  int n_checked = 0;
  int n_cfg = 0;
  int starts [8];
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int stall_left = 0;

  // lines and duration at the start of a phase
  function automatic void drive_phase();
    logic [15:0] len;
    len = cfg_phase;
    case (bus_mode)
      smbme_pkg::OP_WAKE: begin
        if (bus_step == 2'd0) begin
          bus_scl = 1'b1;
          bus_sda = 1'b1;
        end else if (bus_step == 2'd1) begin
          bus_scl = 1'b0;
          len = cfg_wake;
        end else bus_scl = 1'b1;
      end
      smbme_pkg::OP_START: begin
        if (bus_step == 2'd0) bus_sda = 1'b1;
        else if (bus_step == 2'd1) bus_scl = 1'b1;
        else if (bus_step == 2'd2) bus_sda = 1'b0;
        else bus_scl = 1'b0;
      end
      smbme_pkg::OP_STOP: begin
        if (bus_step == 2'd0) bus_sda = 1'b0;
        else if (bus_step == 2'd1) bus_scl = 1'b1;
        else bus_sda = 1'b1;
      end
      smbme_pkg::OP_WRITE: begin
        if (bus_bit < 4'd8) begin
          if (bus_step == 2'd0) bus_scl = 1'b0;
          else if (bus_step == 2'd1) bus_sda = bus_shift[7];
          else bus_scl = 1'b1;
        end else begin
          if (bus_step == 2'd0) begin
            bus_scl = 1'b0;
            bus_sda = 1'b1;
          end else bus_scl = (bus_step == 2'd1);
        end
      end
      smbme_pkg::OP_READ_ACK, smbme_pkg::OP_READ_NACK: begin
        if (bus_bit < 4'd8) begin
          if (bus_step == 2'd0) begin
            bus_scl = 1'b0;
            bus_sda = 1'b1;
          end else bus_scl = 1'b1;
        end else begin
          // ack bit goes out before the clock rises
          if (bus_step == 2'd0) bus_scl = 1'b0;
          else if (bus_step == 2'd1) bus_sda = (bus_mode == smbme_pkg::OP_READ_NACK);
          else bus_scl = (bus_step == 2'd2);
        end
      end
      default: ;
    endcase
    // zero length counts as one tick; 16-bit counter holds any setting
    bus_cnt = (len == 16'd0) ? 16'd1 : len;
  endfunction

  // sample at the end of a phase, then step on; returns 1 when the operation ends
  function automatic logic close_phase(input logic sd);
    logic reading;
    logic [1:0] last_phase;
    reading = (bus_mode == smbme_pkg::OP_READ_ACK) || (bus_mode == smbme_pkg::OP_READ_NACK);
    if (bus_mode == smbme_pkg::OP_WRITE && bus_bit < 4'd8 && bus_step == 2'd2)
      bus_shift = bus_shift << 1;
    else if (bus_mode == smbme_pkg::OP_WRITE && bus_bit >= 4'd8 && bus_step == 2'd1)
      bus_nack = sd;
    else if (reading && bus_bit < 4'd8 && bus_step == 2'd1)
      bus_shift = {bus_shift[6:0], sd};
    if (bus_mode == smbme_pkg::OP_START) last_phase = 2'd3;
    else if (reading) last_phase = (bus_bit < 4'd8) ? 2'd1 : 2'd3;
    else last_phase = 2'd2;
    if (bus_step < last_phase) begin
      bus_step = bus_step + 2'd1;
    end else if ((bus_mode == smbme_pkg::OP_WRITE || reading) && bus_bit < 4'd8) begin
      bus_bit = bus_bit + 4'd1;
      bus_step = 2'd0;
    end else begin
      if (reading) bus_rx = bus_shift;
      bus_mode = smbme_pkg::OP_IDLE;
      bus_step = 2'd0;
      bus_bit = 4'd0;
      bus_cnt = 16'd0;
      return 1'b1;
    end
    drive_phase();
    return 1'b0;
  endfunction

  // one item into the sequencer copy
  function automatic line_result_t bus_advance(input logic [2:0] f, input logic [7:0] tx,
                                               input logic ma, input logic sd);
    logic fin;
    fin = 1'b0;
    if (f == smbme_pkg::FN_TICK) begin
      if (bus_mode != smbme_pkg::OP_IDLE) begin
        bus_cnt = bus_cnt - 16'd1;
        if (bus_cnt == 16'd0) fin = close_phase(sd);
      end
    end else if (f <= smbme_pkg::FN_READ && bus_mode == smbme_pkg::OP_IDLE) begin
      bus_step = 2'd0;
      bus_bit = 4'd0;
      case (f)
        smbme_pkg::FN_WAKE: bus_mode = smbme_pkg::OP_WAKE;
        smbme_pkg::FN_START: bus_mode = smbme_pkg::OP_START;
        smbme_pkg::FN_STOP: bus_mode = smbme_pkg::OP_STOP;
        smbme_pkg::FN_WRITE: begin
          bus_mode = smbme_pkg::OP_WRITE;
          bus_shift = tx;
          bus_nack = 1'b0;
        end
        default: begin
          bus_mode = ma ? smbme_pkg::OP_READ_ACK : smbme_pkg::OP_READ_NACK;
          bus_shift = 8'h00;
        end
      endcase
      drive_phase();
    end
    return '{scl: bus_scl, sda: bus_sda, busy: (bus_mode != smbme_pkg::OP_IDLE), done: fin,
             rx: bus_rx, nack: bus_nack};
  endfunction

  function automatic string show(input line_result_t r);
    return $sformatf("scl %b sda %b busy %b done %b rx %h nack %b",
                     r.scl, r.sda, r.busy, r.done, r.rx, r.nack);
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // offer one item, wait for the transfer, queue what it should produce
  task automatic send_item(input logic [2:0] f, input logic [7:0] tx, input logic ma,
                           input logic sd, input logic pinned, input line_result_t want);
    int gap;
    line_result_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_func <= f;
    in_tx_byte <= tx;
    in_master_ack <= ma;
    in_sda_level <= sd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (f > smbme_pkg::FN_READ ||
        ((f == smbme_pkg::FN_TICK) == (bus_mode == smbme_pkg::OP_IDLE))) n_ignored++;
    else n_items++;
    if (f != smbme_pkg::FN_TICK && f <= smbme_pkg::FN_READ && bus_mode == smbme_pkg::OP_IDLE)
      starts[f]++;
    pred = bus_advance(f, tx, ma, sd);
    line_q.push_back(pinned ? want : pred);
  endtask

  // ticks until the running operation ends; level 2 means random sda
  task automatic tick_to_idle(input int level, input logic noisy);
    logic sd;
    while (bus_mode != smbme_pkg::OP_IDLE) begin
      sd = (level == 2) ? 1'($urandom) : level[0];
      if (noisy && $urandom_range(99) < 3)
        send_item(3'($urandom_range(7, 1)), 8'($urandom), 1'($urandom), sd, 1'b0, '0);
      else
        send_item(smbme_pkg::FN_TICK, 8'($urandom), 1'($urandom), sd, 1'b0, '0);
    end
  endtask

  task automatic run_command(input logic [2:0] f);
    send_item(f, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
    tick_to_idle(2, 1'b1);
  endtask

  // drop valid and wait for every result to drain
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (line_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // apb write then read back
  task automatic cfg_set(input logic idx, input logic [15:0] val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= {16'h0000, val};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {16'h0000, val}) begin
      errors++;
      $display("%0t: register %0d read back, want %h got %h", $time, idx, val, prdata);
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == smbme_pkg::REG_PHASE_TICKS) cfg_phase = val;
    else cfg_wake = val;
    n_cfg++;
  endtask

  // random traffic under one setting: mostly framed transactions
  task automatic play_session(input logic [15:0] ph, input logic [15:0] wk, input int budget);
    int stop_at;
    int r;
    settle();
    cfg_set(smbme_pkg::REG_PHASE_TICKS, ph);
    cfg_set(smbme_pkg::REG_WAKE_TICKS, wk);
    stop_at = n_items + budget;
    while (n_items < stop_at) begin
      no_idle = ($urandom_range(99) < 15);
      r = $urandom_range(99);
      if (r < 80) begin
        if ($urandom_range(9) == 0) run_command(smbme_pkg::FN_WAKE);
        run_command(smbme_pkg::FN_START);
        repeat ($urandom_range(4, 1))
          run_command($urandom_range(1) ? smbme_pkg::FN_WRITE : smbme_pkg::FN_READ);
        run_command(smbme_pkg::FN_STOP);
      end else if (r < 90) begin
        run_command(3'($urandom_range(5, 1)));
      end else begin
        send_item($urandom_range(1) ? smbme_pkg::FN_TICK : 3'($urandom_range(7, 6)),
                  8'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
      end
    end
    no_idle = 1'b0;
  endtask

  // receiver: random stalls, plus one long hold-off
  always @(negedge clk) begin : recv_side
    int r;
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (no_idle) begin
      out_stall <= 1'b0;
    end else begin
      r = $urandom_range(99);
      if (r < 4) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(40, 8);
      end else if (r < 20) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(2, 0);
      end else out_stall <= 1'b0;
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin : check_results
    line_result_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{scl: out_scl_out, sda: out_sda_out, busy: out_busy_res, done: out_done_res,
              rx: out_rx_byte, nack: out_nack_seen};
      if (line_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %s", $time, show(got));
      end else begin
        want = line_q.pop_front();
        n_checked++;
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch\n  want %s\n  got  %s", $time, show(want), show(got));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin : stimulus
    // sequencer copy after reset
    cfg_phase = smbme_pkg::PHASE_TICKS_RST;
    cfg_wake = smbme_pkg::WAKE_TICKS_RST;
    bus_mode = smbme_pkg::OP_IDLE;
    bus_step = 2'd0;
    bus_cnt = 16'd0;
    bus_bit = 4'd0;
    bus_shift = 8'h00;
    bus_scl = 1'b1;
    bus_sda = 1'b1;
    bus_nack = 1'b0;
    bus_rx = 8'h00;
    foreach (starts[i]) starts[i] = 0;

    // directed: func, tx, mack, sda, reps, pinned, expected lines
    plan = '{
      '{smbme_pkg::FN_TICK, 8'h00, 1'b0, 1'b0, 1, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}},
      '{FN_NOP6, 8'hFF, 1'b1, 1'b1, 1, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}},
      '{FN_NOP7, 8'h00, 1'b0, 1'b0, 1, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}},
      '{smbme_pkg::FN_START, 8'h00, 1'b0, 1'b0, 1, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
      // commands while busy are dropped
      '{smbme_pkg::FN_WRITE, 8'hFF, 1'b1, 1'b1, 1, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
      '{FN_NOP7, 8'hFF, 1'b1, 1'b1, 1, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
      '{smbme_pkg::FN_TICK, 8'h00, 1'b0, 1'b0, 4, 1'b0, '0},
      '{smbme_pkg::FN_TICK, 8'h00, 1'b0, 1'b0, -1, 1'b0, '0},
      // write with the slave leaving sda high: nack
      '{smbme_pkg::FN_WRITE, 8'hFF, 1'b0, 1'b0, 1, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}},
      '{smbme_pkg::FN_TICK, 8'h00, 1'b0, 1'b1, -1, 1'b0, '0},
      '{smbme_pkg::FN_TICK, 8'hFF, 1'b1, 1'b1, 1, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1}},
      // write acked, nack cleared on start
      '{smbme_pkg::FN_WRITE, 8'h00, 1'b0, 1'b0, 1, 1'b1, '{1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
      '{smbme_pkg::FN_TICK, 8'h00, 1'b0, 1'b0, -1, 1'b0, '0},
      // read all ones with master ack
      '{smbme_pkg::FN_READ, 8'h00, 1'b1, 1'b0, 1, 1'b1, '{1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
      '{smbme_pkg::FN_TICK, 8'h00, 1'b0, 1'b1, -1, 1'b0, '0},
      '{smbme_pkg::FN_TICK, 8'h00, 1'b0, 1'b0, 1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 8'hFF, 1'b0}},
      // read all zeros with master nack
      '{smbme_pkg::FN_READ, 8'hFF, 1'b0, 1'b1, 1, 1'b1, '{1'b0, 1'b1, 1'b1, 1'b0, 8'hFF, 1'b0}},
      '{smbme_pkg::FN_TICK, 8'h00, 1'b0, 1'b0, -1, 1'b0, '0},
      '{smbme_pkg::FN_STOP, 8'h00, 1'b0, 1'b0, 1, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}},
      '{smbme_pkg::FN_TICK, 8'h00, 1'b0, 1'b1, -1, 1'b0, '0},
      // wake pulse with a short hold
      '{smbme_pkg::FN_WAKE, 8'h00, 1'b0, 1'b0, 1, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
      '{smbme_pkg::FN_READ, 8'hFF, 1'b1, 1'b1, 1, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
      '{smbme_pkg::FN_TICK, 8'h00, 1'b0, 1'b1, -1, 1'b0, '0},
      '{smbme_pkg::FN_TICK, 8'hFF, 1'b1, 1'b0, 1, 1'b0, '0}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // short wake hold keeps the directed part small
    cfg_set(smbme_pkg::REG_WAKE_TICKS, 16'd40);

    foreach (plan[i]) begin
      if (plan[i].reps < 0) tick_to_idle(int'(plan[i].sda), 1'b0);
      else repeat (plan[i].reps)
        send_item(plan[i].func, plan[i].tx, plan[i].mack, plan[i].sda, plan[i].pinned,
                  plan[i].want);
    end

    // largest register settings written and read back
    settle();
    cfg_set(smbme_pkg::REG_PHASE_TICKS, 16'hFFFF);
    cfg_set(smbme_pkg::REG_WAKE_TICKS, 16'hFFFF);

    // random sessions; the first one carries the long receiver hold-off
    hold_req = 1'b1;
    play_session(16'd1, 16'd1, 150);
    play_session(16'd2, 16'd5, 150);
    play_session(16'd0, 16'd0, 150);
    play_session(16'd3, 16'd2, 150);
    play_session(16'd1, 16'd30, 150);

    settle();
    repeat (5) @(posedge clk);

    $display("run: %0d items taken, %0d ignored, %0d results checked, %0d register writes",
             n_items, n_ignored, n_checked, n_cfg);
    $display("run: %0d wake, %0d start, %0d stop, %0d write, %0d read operations",
             starts[smbme_pkg::FN_WAKE], starts[smbme_pkg::FN_START],
             starts[smbme_pkg::FN_STOP], starts[smbme_pkg::FN_WRITE],
             starts[smbme_pkg::FN_READ]);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
